>>> sv/pdird_pkg.sv
// ----------------------------------------------------------------------------
// pdird_pkg
// Shared types and constants of the pulse-distance infrared frame decoder:
// transaction payloads, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package pdird_pkg;

  // field widths
  localparam int TICK_W  = 15;
  localparam int TOL_W   = 8;
  localparam int SKIP_W  = 4;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SKIP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP       = 2'd3;

  // configuration reset values
  localparam logic [TICK_W-1:0] UNIT_RESET  = 15'd562;
  localparam logic [TOL_W-1:0]  TOL_RESET   = 8'd100;
  localparam logic [SKIP_W-1:0] START_RESET = 4'd1;
  localparam logic [SKIP_W-1:0] STOP_RESET  = 4'd1;

  // all-ones check value of an inverse byte pair
  localparam logic [7:0] PAIR_ALL_ONES = 8'hFF;
  localparam logic [2:0] LAST_BIT_POS  = 3'd7;
  localparam logic [COUNT_W-1:0] SYMBOL_COUNT_MAX = 7'h7F;

  // one receiver symbol
  typedef struct packed {
    logic              first_level;
    logic [TICK_W-1:0] first_ticks;
    logic              second_level;
    logic [TICK_W-1:0] second_ticks;
    logic [COUNT_W-1:0] frame_symbol_count;
    logic              frame_end;
  } symbol_t;

  // one decoded byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] byte_number;
    logic       last_byte;
    logic       symbol_error;
    logic       checksum_error;
  } result_t;

  // verdict on one symbol's halves
  typedef struct packed {
    logic bit_val;
    logic bad;
  } sym_verdict_t;

endpackage

>>> sv/pdird_symbol_check.sv
// ----------------------------------------------------------------------------
// pdird_symbol_check
// Classifies one symbol: checks the separator half against the single-width
// window and decides the bit from the width of the mark half.
// ----------------------------------------------------------------------------
module pdird_symbol_check
  import pdird_pkg::*;
(
  input  logic [TICK_W-1:0] unit_pulse_ticks,
  input  logic [TOL_W-1:0]  pulse_tolerance,
  input  logic              first_level,
  input  logic [TICK_W-1:0] first_ticks,
  input  logic              second_level,
  input  logic [TICK_W-1:0] second_ticks,
  output sym_verdict_t      verdict
);

  logic [TICK_W-1:0] single_lo;
  logic [TICK_W:0]   single_hi;
  logic [TICK_W+1:0] triple_centre;
  logic [TOL_W+1:0]  triple_dev;
  logic [TICK_W+1:0] triple_lo;
  logic [TICK_W+2:0] triple_hi;
  logic first_single;
  logic second_single;
  logic second_triple;

  // single-width window, lower bound clamped at zero
  assign single_lo = (unit_pulse_ticks > TICK_W'(pulse_tolerance)) ?
                     unit_pulse_ticks - TICK_W'(pulse_tolerance) : '0;
  assign single_hi = (TICK_W+1)'(unit_pulse_ticks) + (TICK_W+1)'(pulse_tolerance);

  // triple-width window
  assign triple_centre = {1'b0, unit_pulse_ticks, 1'b0} + (TICK_W+2)'(unit_pulse_ticks);
  assign triple_dev    = {1'b0, pulse_tolerance, 1'b0} + (TOL_W+2)'(pulse_tolerance);
  assign triple_lo = (triple_centre > (TICK_W+2)'(triple_dev)) ?
                     triple_centre - (TICK_W+2)'(triple_dev) : '0;
  assign triple_hi = (TICK_W+3)'(triple_centre) + (TICK_W+3)'(triple_dev);

  assign first_single  = (first_ticks >= single_lo) &&
                         ((TICK_W+1)'(first_ticks) <= single_hi);
  assign second_single = (second_ticks >= single_lo) &&
                         ((TICK_W+1)'(second_ticks) <= single_hi);
  assign second_triple = ((TICK_W+2)'(second_ticks) >= triple_lo) &&
                         ((TICK_W+3)'(second_ticks) <= triple_hi);

  // bit decision
  always_comb begin
    verdict = '0;
    if (first_level || !first_single) begin
      verdict.bad = 1'b1;
    end else if (!second_level) begin
      verdict.bad = 1'b1;
    end else if (second_triple) begin
      verdict.bit_val = 1'b1;
    end else if (!second_single) begin
      verdict.bad = 1'b1;
    end
  end

endmodule

>>> sv/pulse_distance_ir_decoder_core.sv
// ----------------------------------------------------------------------------
// pulse_distance_ir_decoder_core
// Pulse-distance infrared frame decoder: turns receiver symbols into bytes.
// ----------------------------------------------------------------------------
// Usage
//   symbol channel: one receiver symbol per transaction (symbol_valid /
//     symbol_stall). Leading and trailing symbols of a frame, as set by the
//     configuration, are skipped; every data symbol gives one bit.
//   result channel: one decoded byte per transaction (result_valid /
//     result_stall), sent when eight bits are in or the last data bit lands.
//     Most symbols give no result.
//   cfg port: cfg_write with cfg_index and cfg_data sets a register; write
//     only while no symbol is in flight.
//   Path: input register, then decode stage, then output register.
//   Throughput: one symbol per cycle while the result channel does not stall,
//     set by the single decode stage that updates the frame state; the input
//     register and the output register are the only storage on the path.
//   Reset: frame state clears, registers take their defaults, no result.
//   Stall: a held result keeps its value; the input register still drains
//     into the decode stage while the output slot is free, then symbol_stall
//     rises until the byte is taken.
// ----------------------------------------------------------------------------
module pulse_distance_ir_decoder_core
  import pdird_pkg::*;
#(
  parameter int MAX_FRAME_SYMBOLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 symbol_valid,
  output logic                 symbol_stall,
  input  symbol_t              symbol,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam logic [8:0] MAX_COUNT = 9'(MAX_FRAME_SYMBOLS);

  // configuration
  logic [TICK_W-1:0] unit_pulse_ticks;
  logic [TOL_W-1:0]  pulse_tolerance;
  logic [SKIP_W-1:0] start_skip_symbols;
  logic [SKIP_W-1:0] stop_symbols;

  // input register
  logic    in_full;
  symbol_t in_item;
  logic    advance;

  // frame state
  logic [COUNT_W-1:0] symbol_counter;
  logic [2:0]         bit_position;
  logic [7:0]         byte_accumulator;
  logic [3:0]         byte_counter;
  logic [7:0]         even_pair_byte;
  logic               sticky_symbol_error;
  logic               sticky_checksum_error;

  // decode stage
  sym_verdict_t verdict;
  logic [8:0]   count_clamped;
  logic [8:0]   data_end;
  logic [8:0]   data_span;
  logic [8:0]   index_ext;
  logic         is_data;
  logic         is_last;
  logic         four_bytes;
  logic [7:0]   acc_new;
  logic         emit;
  logic         symbol_error_now;
  logic         pair_fail;
  result_t      result_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_pulse_ticks   <= UNIT_RESET;
      pulse_tolerance    <= TOL_RESET;
      start_skip_symbols <= START_RESET;
      stop_symbols       <= STOP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_UNIT_PULSE: unit_pulse_ticks   <= cfg_data[TICK_W-1:0];
        CFG_TOLERANCE:  pulse_tolerance    <= cfg_data[TOL_W-1:0];
        CFG_START_SKIP: start_skip_symbols <= cfg_data[SKIP_W-1:0];
        CFG_STOP:       stop_symbols       <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on whenever the output slot frees
  assign advance      = in_full && (!result_valid || !result_stall);
  assign symbol_stall = in_full && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!symbol_stall) begin
      in_full <= symbol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbol_valid && !symbol_stall) begin
      in_item <= symbol;
    end
  end

  // symbol classification
  pdird_symbol_check u_symbol_check (
    .unit_pulse_ticks (unit_pulse_ticks),
    .pulse_tolerance  (pulse_tolerance),
    .first_level      (in_item.first_level),
    .first_ticks      (in_item.first_ticks),
    .second_level     (in_item.second_level),
    .second_ticks     (in_item.second_ticks),
    .verdict          (verdict)
  );

  // position of the symbol within the data part of the frame
  assign count_clamped = ({2'b00, in_item.frame_symbol_count} > MAX_COUNT) ?
                         MAX_COUNT : {2'b00, in_item.frame_symbol_count};
  assign data_end  = (count_clamped > {5'd0, stop_symbols}) ?
                     count_clamped - {5'd0, stop_symbols} : '0;
  assign data_span = data_end - {5'd0, start_skip_symbols};
  assign index_ext = {2'b00, symbol_counter};
  assign is_data   = (index_ext >= {5'd0, start_skip_symbols}) && (index_ext < data_end);
  assign is_last   = (index_ext == data_end - 9'd1);
  // four data bytes means 25 to 32 data bits
  assign four_bytes = (data_span >= 9'd25) && (data_span <= 9'd32);

  // bit packing and byte completion
  assign acc_new = byte_accumulator | (8'(verdict.bit_val) << bit_position);
  assign emit    = is_data && ((bit_position == LAST_BIT_POS) || is_last);
  assign symbol_error_now = sticky_symbol_error | verdict.bad;
  assign pair_fail = four_bytes && byte_counter[0] &&
                     ((even_pair_byte | acc_new) != PAIR_ALL_ONES);

  always_comb begin
    result_next.data_byte      = acc_new;
    result_next.byte_number    = byte_counter[2:0];
    result_next.last_byte      = is_last;
    result_next.symbol_error   = symbol_error_now;
    result_next.checksum_error = is_last && four_bytes &&
                                 (sticky_checksum_error | pair_fail);
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_counter        <= '0;
      bit_position          <= '0;
      byte_accumulator      <= '0;
      byte_counter          <= '0;
      even_pair_byte        <= '0;
      sticky_symbol_error   <= 1'b0;
      sticky_checksum_error <= 1'b0;
    end else if (advance) begin
      if (in_item.frame_end) begin
        symbol_counter        <= '0;
        bit_position          <= '0;
        byte_accumulator      <= '0;
        byte_counter          <= '0;
        even_pair_byte        <= '0;
        sticky_symbol_error   <= 1'b0;
        sticky_checksum_error <= 1'b0;
      end else begin
        if (symbol_counter != SYMBOL_COUNT_MAX) begin
          symbol_counter <= symbol_counter + 7'd1;
        end
        if (is_data) begin
          sticky_symbol_error <= symbol_error_now;
          if (emit) begin
            if (four_bytes && !byte_counter[0]) begin
              even_pair_byte <= acc_new;
            end
            if (pair_fail) begin
              sticky_checksum_error <= 1'b1;
            end
            byte_counter     <= byte_counter + 4'd1;
            byte_accumulator <= '0;
            bit_position     <= '0;
          end else begin
            byte_accumulator <= acc_new;
            bit_position     <= bit_position + 3'd1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= result_next;
    end
  end

endmodule

>>> sv/pdird_checker.sv
// ----------------------------------------------------------------------------
// pdird_checker
// Port-level checks of the decoder core, bound to every instance.
// ----------------------------------------------------------------------------
module pdird_checker
  import pdird_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 symbol_valid,
  input logic                 symbol_stall,
  input symbol_t              symbol,
  input logic                 result_valid,
  input logic                 result_stall,
  input result_t              result
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // input back-pressure only while a result waits on a stalled receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    symbol_stall |-> (result_valid && result_stall))
    else $error("symbol stall without a blocked result");

  // checksum flag only on the final byte of a frame
  a_checksum_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.checksum_error) |-> result.last_byte)
    else $error("checksum error on a byte that is not last");

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind pulse_distance_ir_decoder_core pdird_checker u_pdird_checker (.*);
